>>> src/imu_sample_time_interpolator_core_macros.svh
// Assertion macros for the IMU sample interpolator.
`ifndef IMU_SAMPLE_TIME_INTERPOLATOR_CORE_MACROS_SVH
`define IMU_SAMPLE_TIME_INTERPOLATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ISTI_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("isti assertion failed");
`define ISTI_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("isti assertion failed");
`else
`define ISTI_ASSERT(lbl, prop)
`define ISTI_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> src/isti_pkg.sv
package isti_pkg;
   localparam int TIME_W  = 48;
   localparam int GAP_W   = 24;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 3;
   localparam int NUM_CH  = 6;
   localparam logic [GAP_W-1:0] MAX_GAP_RESET = 24'd100000;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FEW       = 3'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_GAP       = 3'd3;
   localparam logic [STAT_W-1:0] STAT_ORDER     = 3'd4;
endpackage

>>> src/isti_ram.sv
module isti_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/isti_div.sv
module isti_div #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 26,
   parameter int Q_W   = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [Q_W-1:0]   quot
);
   localparam int CNT_W = $clog2(Q_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   low_ff, low_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      trial   = {rem_ff, low_ff[Q_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DEN_W'(num[NUM_W-1:Q_W]);
         low_in  = num[Q_W-1:0];
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         low_in = {low_ff[Q_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in   = {q_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

>>> src/isti_lerp.sv
module isti_lerp
   import isti_pkg::*;
#(
   parameter int SW = 24,
   parameter int LB = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [LB:0]        lam,
   input  logic [NUM_CH*SW-1:0] row0,
   input  logic [NUM_CH*SW-1:0] row1,
   output logic               done,
   output logic [NUM_CH*SW-1:0] row_out
);
   localparam int PW = SW + LB + 3;

   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic                 done_ff, done_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [LB:0]          lam_ff, lam_in;
   logic [NUM_CH*SW-1:0] r0_ff, r0_in;
   logic [NUM_CH*SW-1:0] r1_ff, r1_in;
   logic [NUM_CH*SW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [SW-1:0]        v0_ff, v0_in;
   logic signed [SW:0]   diff;
   logic signed [PW-1:0] rounded;
   logic signed [PW-1:0] shifted;
   logic [SW-1:0]        res;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      lam_in   = lam_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      v0_in    = v0_ff;
      diff     = $signed({r1_ff[SW-1], r1_ff[SW-1:0]}) - $signed({r0_ff[SW-1], r0_ff[SW-1:0]});
      rounded  = prod_ff + $signed(PW'(1) <<< (LB - 1));
      shifted  = rounded >>> LB;
      res      = v0_ff + shifted[SW-1:0];
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         lam_in   = lam;
         r0_in    = row0;
         r1_in    = row1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            prod_in  = PW'($signed({1'b0, lam_ff}) * diff);
            v0_in    = r0_ff[SW-1:0];
            phase_in = 1'b1;
         end else begin
            acc_in   = {res, acc_ff[NUM_CH*SW-1:SW]};
            r0_in    = r0_ff >> SW;
            r1_in    = r1_ff >> SW;
            phase_in = 1'b0;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 3'(NUM_CH - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      lam_ff  <= lam_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      v0_ff   <= v0_in;
   end

   assign done    = done_ff;
   assign row_out = acc_ff;
endmodule

>>> src/imu_sample_time_interpolator_core.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    cmd, timestamp, six samples
// rsp       out        rsp_valid/stall    status, six interpolated samples
// csr       in         csr_we             max_gap
//
// Push, clear and unused commands: the result goes through ST_DONE to the response register.
// Query: binary search on the time RAM, neighbor reads and gap check, the divider, the shared
// interpolation multiplier and the result register, in that order.
// Reset is synchronous; the sample RAMs need no clearing.
// req_stall is high while a transaction is in work; a held result stalls the last step.
`include "imu_sample_time_interpolator_core_macros.svh"
module imu_sample_time_interpolator_core
   import isti_pkg::*;
#(
   parameter int DEPTH        = 256,
   parameter int SAMPLE_WIDTH = 24,
   parameter int LAMBDA_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [TIME_W-1:0]       req_timestamp,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_z,
   input  logic [SAMPLE_WIDTH-1:0] req_gyro_x,
   input  logic [SAMPLE_WIDTH-1:0] req_gyro_y,
   input  logic [SAMPLE_WIDTH-1:0] req_gyro_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_accel_x,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_accel_y,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_accel_z,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_gyro_x,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_gyro_y,
   output logic [SAMPLE_WIDTH-1:0] rsp_out_gyro_z,
   input  logic                    csr_we,
   input  logic [GAP_W-1:0]        csr_wdata
);
   localparam int SW    = SAMPLE_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int RW    = NUM_CH * SW;
   localparam int Q_W   = LAMBDA_BITS + 1;
   localparam int SPN_W = GAP_W + 1;
   localparam int DEN_W = GAP_W + 2;
   localparam int NUM_W = GAP_W + LAMBDA_BITS + 2;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_SRCH = 9'b000000010,
      ST_CMP  = 9'b000000100,
      ST_NBR0 = 9'b000001000,
      ST_NBR1 = 9'b000010000,
      ST_GAP  = 9'b000100000,
      ST_DIV  = 9'b001000000,
      ST_LERP = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] k);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, k};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [TIME_W-1:0] newest_ff, newest_in;
   logic [GAP_W-1:0]  max_gap_ff, max_gap_in;
   logic [TIME_W-1:0] t_ff, t_in;
   logic [TIME_W-1:0] t0_ff, t0_in;
   logic [TIME_W-1:0] t1_ff, t1_in;
   logic [RW-1:0]     row0_ff, row0_in;
   logic [RW-1:0]     row1_ff, row1_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     mid_ff, mid_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [RW-1:0]     res_row_ff, res_row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [RW-1:0]     rsp_row_ff, rsp_row_in;

   logic              req_take;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [TIME_W-1:0] time_rd;
   logic [RW-1:0]     row_rd;
   logic [RW-1:0]     row_wr;
   logic [TIME_W-1:0] d0, d1;
   logic [SPN_W-1:0]  span;
   logic              div_start, div_done;
   logic [Q_W-1:0]    lam;
   logic              lerp_start, lerp_done;
   logic [RW-1:0]     lerp_row;
   logic [CW-1:0]     mid_calc;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign row_wr = {req_gyro_z, req_gyro_y, req_gyro_x, req_accel_z, req_accel_y, req_accel_x};
   assign d0 = t_ff - t0_ff;
   assign d1 = t1_ff - t_ff;
   assign span = SPN_W'(d0[GAP_W-1:0]) + SPN_W'(d1[GAP_W-1:0]);
   assign mid_calc = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      max_gap_in    = csr_we ? csr_wdata : max_gap_ff;
      t_in          = t_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      row0_in       = row0_ff;
      row1_in       = row1_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_row_in    = res_row_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_of(oldest_ff, count_ff[AW-1:0]);
      rd_addr       = slot_of(oldest_ff, lo_ff[AW-1:0]);
      div_start     = 1'b0;
      lerp_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               t_in          = req_timestamp;
               res_status_in = STAT_OK;
               res_row_in    = '0;
               lo_in         = '0;
               hi_in         = count_ff;
               state_in      = ST_DONE;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (count_ff != '0 && req_timestamp < newest_ff) begin
                        res_status_in = STAT_ORDER;
                     end else begin
                        wr_en     = 1'b1;
                        newest_in = req_timestamp;
                        if (count_ff == CW'(DEPTH)) begin
                           wr_addr   = oldest_ff;
                           oldest_in = slot_of(oldest_ff, AW'(1));
                        end else begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff < CW'(2)) begin
                        res_status_in = STAT_FEW;
                     end else begin
                        state_in = ST_SRCH;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in  = '0;
                     oldest_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SRCH: begin
            if (lo_ff == hi_ff) begin
               if (lo_ff == '0 || lo_ff == count_ff) begin
                  res_status_in = STAT_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  rd_addr  = slot_of(oldest_ff, AW'(lo_ff - 1'b1));
                  state_in = ST_NBR0;
               end
            end else begin
               mid_in   = mid_calc;
               rd_addr  = slot_of(oldest_ff, mid_calc[AW-1:0]);
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (t_ff < time_rd) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = ST_SRCH;
         end
         ST_NBR0: begin
            t0_in    = time_rd;
            row0_in  = row_rd;
            state_in = ST_NBR1;
         end
         ST_NBR1: begin
            t1_in    = time_rd;
            row1_in  = row_rd;
            state_in = ST_GAP;
         end
         ST_GAP: begin
            if (d0 > TIME_W'(max_gap_ff) || d1 > TIME_W'(max_gap_ff)) begin
               res_status_in = STAT_GAP;
               state_in      = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               lerp_start = 1'b1;
               state_in   = ST_LERP;
            end
         end
         ST_LERP: begin
            if (lerp_done) begin
               res_row_in = lerp_row;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_row_in    = res_row_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         max_gap_ff   <= MAX_GAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         max_gap_ff   <= max_gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      newest_ff     <= newest_in;
      t_ff          <= t_in;
      t0_ff         <= t0_in;
      t1_ff         <= t1_in;
      row0_ff       <= row0_in;
      row1_ff       <= row1_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_row_ff    <= res_row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
   end

   isti_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_timestamp),
      .rd_addr (rd_addr),
      .rd_data (time_rd)
   );

   isti_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (row_wr),
      .rd_addr (rd_addr),
      .rd_data (row_rd)
   );

   isti_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (NUM_W'({d0[GAP_W-1:0], Q_W'(0)}) + NUM_W'(span)),
      .den   ({span, 1'b0}),
      .done  (div_done),
      .quot  (lam)
   );

   isti_lerp #(.SW(SW), .LB(LAMBDA_BITS)) u_lerp (
      .clock   (clock),
      .reset   (reset),
      .start   (lerp_start),
      .lam     (lam),
      .row0    (row0_ff),
      .row1    (row1_ff),
      .done    (lerp_done),
      .row_out (lerp_row)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_accel_x = rsp_row_ff[0*SW +: SW];
   assign rsp_out_accel_y = rsp_row_ff[1*SW +: SW];
   assign rsp_out_accel_z = rsp_row_ff[2*SW +: SW];
   assign rsp_out_gyro_x  = rsp_row_ff[3*SW +: SW];
   assign rsp_out_gyro_y  = rsp_row_ff[4*SW +: SW];
   assign rsp_out_gyro_z  = rsp_row_ff[5*SW +: SW];

   `ISTI_ASSERT(a_count_bound, count_ff <= CW'(DEPTH))
   `ISTI_ASSERT(a_search_order, (state_ff == ST_SRCH || state_ff == ST_CMP) |-> lo_ff <= hi_ff)
   `ISTI_ASSERT(a_lambda_bound, lerp_start |-> lam <= Q_W'(1 << LAMBDA_BITS))
   `ISTI_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff))
endmodule
